// ----- rtl/shamir_three_pass_round_trip_assert.svh -----
// Assertion macros used by the checker file of this project.
// Each macro checks an implication at the rising clock edge and is off in reset.
`ifndef SHAMIR_THREE_PASS_ROUND_TRIP_ASSERT_SVH
`define SHAMIR_THREE_PASS_ROUND_TRIP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-pass round trip package
// Shared types and codes of the three-pass exchange block.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_KEY_A   = 2'd1;
  localparam logic [1:0] REG_KEY_B   = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD_A = 2'd1;
  localparam logic [1:0] ST_BAD_B = 2'd2;

  // Handshake between the sequencer and an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Sequencer states.
  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_INV_RED   = 14'b00000000000010,
    S_INV_RED_W = 14'b00000000000100,
    S_INV_CHK   = 14'b00000000001000,
    S_INV_DIV_W = 14'b00000000010000,
    S_INV_MUL   = 14'b00000000100000,
    S_INV_MUL_W = 14'b00000001000000,
    S_EXP_RED   = 14'b00000010000000,
    S_EXP_RED_W = 14'b00000100000000,
    S_EXP_CHK   = 14'b00001000000000,
    S_EXP_MUL_W = 14'b00010000000000,
    S_EXP_SQR   = 14'b00100000000000,
    S_EXP_SQR_W = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/stp_if.sv -----
// ----------------------------------------------------------------------------
// Three-pass round trip channels
// Valid/ready channels for the message beat and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_in_if #(
  parameter int WORD_BITS = 31
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink (input valid, input message, output ready);
endinterface

interface stp_out_if #(
  parameter int WORD_BITS = 31
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] pass_one;
  logic [WORD_BITS-1:0] pass_two;
  logic [WORD_BITS-1:0] pass_three;
  logic [WORD_BITS-1:0] recovered;
  logic [WORD_BITS-1:0] inverse_a;
  logic [WORD_BITS-1:0] inverse_b;
  logic                 matched;
  logic [1:0]           status;

  modport source (output valid, output pass_one, output pass_two, output pass_three,
                  output recovered, output inverse_a, output inverse_b,
                  output matched, output status, input ready);
  modport sink (input valid, input pass_one, input pass_two, input pass_three,
                input recovered, input inverse_a, input inverse_b,
                input matched, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/stp_mulmod.sv -----
// ----------------------------------------------------------------------------
// Shift-add modular multiplier
// Computes a * b mod m one multiplier bit per cycle, MSB first; b must be below m.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_mulmod import stp_pkg::*; #(
  parameter int WORD_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  input  wire logic [WORD_BITS-1:0] m_i,
  output logic      [WORD_BITS-1:0] res_o,
  output unit_sts_t                 sts_o
);

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(WORD_BITS);

  logic [WORD_BITS-1:0] a_q, b_q, m_q, acc_q, acc_d;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic [WORD_BITS:0]   dbl, sum;
  logic [WORD_BITS-1:0] red;

  // One step: double, reduce, add the multiplicand when the bit is set, reduce.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    red   = (dbl >= {1'b0, m_q}) ? WORD_BITS'(dbl - {1'b0, m_q}) : dbl[WORD_BITS-1:0];
    sum   = {1'b0, red} + (a_q[WORD_BITS-1] ? {1'b0, b_q} : '0);
    acc_d = (sum >= {1'b0, m_q}) ? WORD_BITS'(sum - {1'b0, m_q}) : sum[WORD_BITS-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_INIT;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[WORD_BITS-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign res_o = acc_q;
  assign sts_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- rtl/stp_divider.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle; divisor nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_divider import stp_pkg::*; #(
  parameter int WORD_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] num_i,
  input  wire logic [WORD_BITS-1:0] den_i,
  output logic      [WORD_BITS-1:0] quo_o,
  output logic      [WORD_BITS-1:0] rem_o,
  output unit_sts_t                 sts_o
);

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(WORD_BITS);

  logic [WORD_BITS-1:0] num_q, den_q, rem_q, rem_d;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q, take;
  logic [WORD_BITS:0]   trial;

  // Bring down the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_q, num_q[WORD_BITS-1]};
    take  = trial >= {1'b0, den_q};
    rem_d = take ? WORD_BITS'(trial - {1'b0, den_q}) : trial[WORD_BITS-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_INIT;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register collects quotient bits as it shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[WORD_BITS-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign quo_o = num_q;
  assign rem_o = rem_q;
  assign sts_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- rtl/shamir_three_pass_round_trip.sv -----
// The block finds both key inverses, each by one reduction of the key and then
// extended Euclid steps of one division and one multiply each, then computes four
// powers of up to 2*WORD_BITS+1 multiplies each. It takes one message at a time; the
// shared shift-add multiplier and the divider serve every step. Reset clears the
// sequencer and loads modulus 3 and both keys 1.
// ----------------------------------------------------------------------------
// Shamir three-pass round trip
// Key inverses by extended Euclid, then the four modular powers of the exchange.
// ----------------------------------------------------------------------------
`default_nettype none

module shamir_three_pass_round_trip import stp_pkg::*; #(
  parameter int WORD_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [WORD_BITS-1:0] cfg_data_i,
  stp_in_if.sink                    in_i,
  stp_out_if.source                 out_o
);

  state_e state_q, state_d;

  logic [WORD_BITS-1:0] modulus_q, key_a_q, key_b_q;
  logic [WORD_BITS-1:0] p_q, n_q, msg_q;
  logic [WORD_BITS-1:0] r0_q, r1_q, t0_q, t1_q, q_q, tr_q;
  logic [WORD_BITS-1:0] inv_a_q, inv_b_q;
  logic [WORD_BITS-1:0] acc_q, base_q, exp_q;
  logic [WORD_BITS-1:0] x_q [4];
  logic [1:0]           phase_q, status_q;
  logic                 ksel_q;

  logic                 mm_start, dv_start;
  logic [WORD_BITS-1:0] mm_a, mm_b, mm_m, mm_res;
  logic [WORD_BITS-1:0] dv_num, dv_den, dv_quo, dv_rem;
  unit_sts_t            mm_sts, dv_sts;

  logic [WORD_BITS-1:0] p_in, key_sel, exp_sel, base_sel, t_new;
  logic                 out_free, err;

  localparam logic [WORD_BITS-1:0] ONE   = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] THREE = WORD_BITS'(3);

  // Shared arithmetic units.
  stp_mulmod #(.WORD_BITS(WORD_BITS)) u_mulmod (
    .clk_i, .rst_ni, .start_i(mm_start), .a_i(mm_a), .b_i(mm_b), .m_i(mm_m),
    .res_o(mm_res), .sts_o(mm_sts)
  );

  stp_divider #(.WORD_BITS(WORD_BITS)) u_divider (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .quo_o(dv_quo), .rem_o(dv_rem), .sts_o(dv_sts)
  );

  // Operand selection.
  always_comb begin
    p_in     = (modulus_q < THREE) ? THREE : modulus_q;
    key_sel  = ksel_q ? key_b_q : key_a_q;
    base_sel = (phase_q == 2'd0) ? msg_q : x_q[phase_q - 2'd1];
    unique case (phase_q)
      2'd0:    exp_sel = key_a_q;
      2'd1:    exp_sel = key_b_q;
      2'd2:    exp_sel = inv_a_q;
      default: exp_sel = inv_b_q;
    endcase
    // New Bezout coefficient t0 - q*t1, kept modulo n.
    t_new    = (t0_q >= mm_res) ? t0_q - mm_res : t0_q + (n_q - mm_res);
    out_free = !out_o.valid || out_o.ready;
    err      = status_q != ST_OK;
  end

  // Sequencer next state and unit starts.
  always_comb begin
    state_d  = state_q;
    mm_start = 1'b0;
    mm_a     = base_q;
    mm_b     = base_q;
    mm_m     = p_q;
    dv_start = 1'b0;
    dv_num   = r0_q;
    dv_den   = r1_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_INV_RED;
      end
      S_INV_RED: begin
        dv_start = 1'b1;
        dv_num   = key_sel;
        dv_den   = n_q;
        state_d  = S_INV_RED_W;
      end
      S_INV_RED_W: begin
        if (dv_sts.done) state_d = S_INV_CHK;
      end
      S_INV_CHK: begin
        if (r1_q == '0) begin
          if (r0_q != ONE) state_d = S_OUT;
          else if (!ksel_q) state_d = S_INV_RED;
          else state_d = S_EXP_RED;
        end else begin
          dv_start = 1'b1;
          state_d  = S_INV_DIV_W;
        end
      end
      S_INV_DIV_W: begin
        if (dv_sts.done) state_d = S_INV_MUL;
      end
      S_INV_MUL: begin
        mm_start = 1'b1;
        mm_a     = q_q;
        mm_b     = t1_q;
        mm_m     = n_q;
        state_d  = S_INV_MUL_W;
      end
      S_INV_MUL_W: begin
        if (mm_sts.done) state_d = S_INV_CHK;
      end
      S_EXP_RED: begin
        // Reduce the base modulo p by multiplying it with one.
        mm_start = 1'b1;
        mm_a     = base_sel;
        mm_b     = ONE;
        state_d  = S_EXP_RED_W;
      end
      S_EXP_RED_W: begin
        if (mm_sts.done) state_d = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        if (exp_q == '0) begin
          state_d = (phase_q == 2'd3) ? S_OUT : S_EXP_RED;
        end else if (exp_q[0]) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          state_d  = S_EXP_MUL_W;
        end else begin
          state_d = S_EXP_SQR;
        end
      end
      S_EXP_MUL_W: begin
        if (mm_sts.done) state_d = S_EXP_SQR;
      end
      S_EXP_SQR: begin
        mm_start = 1'b1;
        state_d  = S_EXP_SQR_W;
      end
      S_EXP_SQR_W: begin
        if (mm_sts.done) state_d = S_EXP_CHK;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = state_q == S_IDLE;

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= THREE;
      key_a_q     <= ONE;
      key_b_q     <= ONE;
      out_o.valid <= 1'b0;
      ksel_q      <= 1'b0;
      phase_q     <= 2'd0;
      status_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODULUS: modulus_q <= cfg_data_i;
          REG_KEY_A:   key_a_q   <= cfg_data_i;
          REG_KEY_B:   key_b_q   <= cfg_data_i;
          default:     ;
        endcase
      end
      if (state_q == S_OUT && out_free) out_o.valid <= 1'b1;
      else if (out_o.valid && out_o.ready) out_o.valid <= 1'b0;
      if (state_q == S_IDLE && in_i.valid) begin
        ksel_q   <= 1'b0;
        status_q <= ST_OK;
      end
      if (state_q == S_INV_CHK && r1_q == '0) begin
        if (r0_q != ONE) status_q <= ksel_q ? ST_BAD_B : ST_BAD_A;
        else if (!ksel_q) ksel_q <= 1'b1;
        else phase_q <= 2'd0;
      end
      if (state_q == S_EXP_CHK && exp_q == '0) phase_q <= phase_q + 2'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          msg_q <= in_i.message;
          p_q   <= p_in;
          n_q   <= p_in - ONE;
        end
      end
      S_INV_RED_W: begin
        if (dv_sts.done) begin
          r0_q <= n_q;
          r1_q <= dv_rem;
          t0_q <= '0;
          t1_q <= ONE;
        end
      end
      S_INV_CHK: begin
        if (r1_q == '0 && r0_q == ONE) begin
          if (ksel_q) inv_b_q <= t0_q;
          else inv_a_q <= t0_q;
        end
      end
      S_INV_DIV_W: begin
        if (dv_sts.done) begin
          q_q  <= dv_quo;
          tr_q <= dv_rem;
        end
      end
      S_INV_MUL_W: begin
        if (mm_sts.done) begin
          r0_q <= r1_q;
          r1_q <= tr_q;
          t0_q <= t1_q;
          t1_q <= t_new;
        end
      end
      S_EXP_RED: begin
        acc_q <= ONE;
        exp_q <= exp_sel;
      end
      S_EXP_RED_W: begin
        if (mm_sts.done) base_q <= mm_res;
      end
      S_EXP_CHK: begin
        if (exp_q == '0) x_q[phase_q] <= acc_q;
      end
      S_EXP_MUL_W: begin
        if (mm_sts.done) acc_q <= mm_res;
      end
      S_EXP_SQR_W: begin
        if (mm_sts.done) begin
          base_q <= mm_res;
          exp_q  <= {1'b0, exp_q[WORD_BITS-1:1]};
        end
      end
      default: ;
    endcase
  end

  // Result register; a failed key gives zero in every field but the status.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_o.pass_one   <= err ? '0 : x_q[0];
      out_o.pass_two   <= err ? '0 : x_q[1];
      out_o.pass_three <= err ? '0 : x_q[2];
      out_o.recovered  <= err ? '0 : x_q[3];
      out_o.inverse_a  <= err ? '0 : inv_a_q;
      out_o.inverse_b  <= err ? '0 : inv_b_q;
      out_o.matched    <= !err && (x_q[3] == msg_q);
      out_o.status     <= status_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stp_checker.sv -----
// ----------------------------------------------------------------------------
// Three-pass round trip checker
// Port-level checks of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shamir_three_pass_round_trip_assert.svh"

module stp_checker import stp_pkg::*; #(
  parameter int WORD_BITS = 31
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [WORD_BITS-1:0] recovered,
  input wire logic [WORD_BITS-1:0] inverse_a,
  input wire logic                 matched,
  input wire logic [1:0]           status
);

  // A pending result beat holds until it is taken.
  `STP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)

  // The block works on one message at a time.
  `STP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // A failed key zeroes the recovered word, the first inverse and the match flag.
  `STP_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid && status != ST_OK,
                  recovered == '0 && inverse_a == '0 && !matched)

  // Only the three defined status codes appear.
  `STP_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid,
                  status == ST_OK || status == ST_BAD_A || status == ST_BAD_B)

endmodule

bind shamir_three_pass_round_trip stp_checker #(.WORD_BITS(WORD_BITS)) u_stp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .recovered (out_o.recovered),
  .inverse_a (out_o.inverse_a),
  .matched   (out_o.matched),
  .status    (out_o.status)
);

`default_nettype wire

// ----- tb/shamir_three_pass_round_trip_test.sv -----
// ----------------------------------------------------------------------------
// Three-pass round trip testbench
// Drives message beats through the block under a series of modulus and key
// settings, predicts or looks up each result beat and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none

module shamir_three_pass_round_trip_test;
  import stp_pkg::*;

  localparam int WB = 31;
  localparam logic [WB-1:0] MAX_WORD = {WB{1'b1}};
  localparam longint CYCLE_LIMIT = 9_000_000;
  localparam int DIRECTED_ROWS = 19;

  typedef struct {
    logic [WB-1:0] pass_one;
    logic [WB-1:0] pass_two;
    logic [WB-1:0] pass_three;
    logic [WB-1:0] recovered;
    logic [WB-1:0] inverse_a;
    logic [WB-1:0] inverse_b;
    logic          matched;
    logic [1:0]    status;
  } round_trip_t;

  typedef struct {
    logic [WB-1:0] modulus;
    logic [WB-1:0] key_a;
    logic [WB-1:0] key_b;
    logic [WB-1:0] message;
    bit            typed;
    round_trip_t   want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [WB-1:0] cfg_data_i;

  stp_in_if #(.WORD_BITS(WB)) in_if ();
  stp_out_if #(.WORD_BITS(WB)) out_if ();

  shamir_three_pass_round_trip #(.WORD_BITS(WB)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Local copy of the configuration registers.
  logic [WB-1:0] cur_modulus;
  logic [WB-1:0] cur_key_a;
  logic [WB-1:0] cur_key_b;

  round_trip_t pending_results[$];
  int  error_count;
  bit  quiet;
  longint cycle_count;
  stim_row_t rows[DIRECTED_ROWS];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Modular power by square and multiply; products fit in 62 bits.
  function automatic longint unsigned power_mod(longint unsigned base,
                                                longint unsigned expo,
                                                longint unsigned p);
    longint unsigned acc;
    longint unsigned b;
    acc = 1 % p;
    b = base % p;
    while (expo != 0) begin
      if (expo[0]) acc = (acc * b) % p;
      b = (b * b) % p;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; returns 0 when c has no inverse modulo n.
  function automatic bit find_inverse(longint unsigned c, longint unsigned n,
                                      output longint unsigned inv);
    longint r0, r1, t0, t1, q, tr, tt;
    r0 = longint'(n);
    r1 = longint'(c % n);
    t0 = 0;
    t1 = 1;
    inv = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      tr = r0 - q * r1;
      tt = t0 - q * t1;
      r0 = r1;
      r1 = tr;
      t0 = t1;
      t1 = tt;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 = t0 + longint'(n);
    inv = longint'(t0) % n;
    return 1'b1;
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Expected result beat for one message under the current settings.
  function automatic round_trip_t three_pass_predict(logic [WB-1:0] msg);
    round_trip_t r;
    longint unsigned p, n, da, db, x1, x2, x3, x4;
    r = '{default: '0};
    r.status = ST_OK;
    p = (cur_modulus < 3) ? 3 : cur_modulus;
    n = p - 1;
    if (!find_inverse(cur_key_a, n, da)) begin
      r.status = ST_BAD_A;
      return r;
    end
    if (!find_inverse(cur_key_b, n, db)) begin
      r.status = ST_BAD_B;
      return r;
    end
    x1 = power_mod(msg, cur_key_a, p);
    x2 = power_mod(x1, cur_key_b, p);
    x3 = power_mod(x2, da, p);
    x4 = power_mod(x3, db, p);
    r.pass_one = x1[WB-1:0];
    r.pass_two = x2[WB-1:0];
    r.pass_three = x3[WB-1:0];
    r.recovered = x4[WB-1:0];
    r.inverse_a = da[WB-1:0];
    r.inverse_b = db[WB-1:0];
    r.matched = (x4 == msg);
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic compare_field(string what, longint unsigned got, longint unsigned want);
    if (got !== want) report(what, got, want);
  endtask

  // Result side: random back-pressure, quiet stretch on request.
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 29);
  end

  // Result checker.
  always @(posedge clk_i) begin
    round_trip_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result beat", 0, 0);
      end else begin
        w = pending_results.pop_front();
        compare_field("pass_one", out_if.pass_one, w.pass_one);
        compare_field("pass_two", out_if.pass_two, w.pass_two);
        compare_field("pass_three", out_if.pass_three, w.pass_three);
        compare_field("recovered", out_if.recovered, w.recovered);
        compare_field("inverse_a", out_if.inverse_a, w.inverse_a);
        compare_field("inverse_b", out_if.inverse_b, w.inverse_b);
        compare_field("matched", out_if.matched, w.matched);
        compare_field("status", out_if.status, w.status);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [WB-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_MODULUS: cur_modulus = data;
      REG_KEY_A:   cur_key_a = data;
      default:     cur_key_b = data;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Settings change only with the block idle.
  task automatic apply_settings(logic [WB-1:0] m, logic [WB-1:0] a, logic [WB-1:0] b);
    if (m != cur_modulus || a != cur_key_a || b != cur_key_b) begin
      wait_drained();
      write_reg(REG_MODULUS, m);
      write_reg(REG_KEY_A, a);
      write_reg(REG_KEY_B, b);
    end
  endtask

  // Sends one message beat; the expectation is stored at acceptance and the
  // valid line drops at the next falling edge.
  task automatic send_message(logic [WB-1:0] msg, bit typed, round_trip_t want);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 29) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.message = msg;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    pending_results.push_back(typed ? want : three_pass_predict(msg));
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic fill_rows();
    round_trip_t z;
    z = '{default: '0};
    rows[0] = '{3, 1, 1, 0, 1, '{0, 0, 0, 0, 1, 1, 1, ST_OK}};
    rows[1] = '{3, 1, 1, 2, 1, '{2, 2, 2, 2, 1, 1, 1, ST_OK}};
    rows[2] = '{3, 1, 1, MAX_WORD, 0, z};
    z.status = ST_BAD_A;
    rows[3] = '{7, 0, 1, 5, 1, z};
    rows[4] = '{7, 2, 2, 5, 1, z};
    rows[5] = '{MAX_WORD, MAX_WORD - 1, 1, 9, 1, z};
    z.status = ST_BAD_B;
    rows[6] = '{7, 5, 3, 5, 1, z};
    rows[7] = '{MAX_WORD, 1, MAX_WORD - 1, 9, 1, z};
    z.status = ST_OK;
    rows[8] = '{0, 1, 1, 1, 0, z};
    rows[9] = '{1, 1, 1, 2, 0, z};
    rows[10] = '{2, 1, 1, MAX_WORD, 0, z};
    rows[11] = '{11, 13, 17, 6, 0, z};
    rows[12] = '{15, 3, 5, 7, 0, z};
    rows[13] = '{13, 5, 7, 20, 0, z};
    rows[14] = '{MAX_WORD, 5, 13, 123456789, 0, z};
    rows[15] = '{MAX_WORD, 5, 13, MAX_WORD, 0, z};
    rows[16] = '{MAX_WORD, 5, 13, 0, 0, z};
    rows[17] = '{MAX_WORD, 5, 13, MAX_WORD - 1, 0, z};
    rows[18] = '{65537, MAX_WORD, 65539, 65536, 0, z};
  endtask

  function automatic logic [WB-1:0] pick_key(longint unsigned p, bit coprime);
    logic [WB-1:0] k;
    for (int t = 0; t < 30; t++) begin
      k = ($urandom_range(0, 3) == 0) ? ($urandom() & MAX_WORD)
                                      : $urandom_range(1, p - 2 > 1 ? p - 2 : 1);
      if (!coprime || gcd_of(k, p - 1) == 1) return k;
    end
    return 1;
  endfunction

  // Main sequence.
  initial begin
    logic [WB-1:0] primes[10];
    logic [WB-1:0] m, a, b, msg;
    longint unsigned p;
    round_trip_t none;
    none = '{default: '0};
    primes = '{3, 5, 7, 11, 13, 17, 257, 65537, 1000003, MAX_WORD};
    error_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MODULUS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.message = '0;
    out_if.ready = 1'b0;
    cur_modulus = 3;
    cur_key_a = 1;
    cur_key_b = 1;
    fill_rows();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      apply_settings(rows[i].modulus, rows[i].key_a, rows[i].key_b);
      send_message(rows[i].message, rows[i].typed, rows[i].want);
    end

    // Random phases of eight beats each.
    for (int ph = 0; ph < 10; ph++) begin
      m = ($urandom_range(0, 9) == 0) ? ($urandom() & MAX_WORD)
                                      : primes[$urandom_range(0, 9)];
      p = (m < 3) ? 3 : m;
      a = pick_key(p, $urandom_range(0, 9) != 0);
      b = pick_key(p, $urandom_range(0, 9) != 0);
      wait_drained();
      quiet = (ph == 5);
      write_reg(REG_MODULUS, m);
      write_reg(REG_KEY_A, a);
      write_reg(REG_KEY_B, b);
      for (int j = 0; j < 8; j++) begin
        msg = ($urandom_range(0, 4) == 0) ? ($urandom() & MAX_WORD)
                                          : $urandom_range(0, p - 1);
        send_message(msg, 1'b0, none);
      end
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;
    quiet = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_if.sv
rtl/stp_mulmod.sv
rtl/stp_divider.sv
rtl/shamir_three_pass_round_trip.sv
rtl/stp_checker.sv
tb/shamir_three_pass_round_trip_test.sv
